### design/u8e_pkg.sv
// ----------------------------------------------------------------------------
// u8e_pkg
// Shared types, constants and encoding helpers for the UTF-16 to UTF-8
// encoder.
// ----------------------------------------------------------------------------
package u8e_pkg;

  // input item: one utf-16 code unit and its end-of-string mark
  typedef struct packed {
    logic [15:0] code_unit;
    logic        final_unit;
  } in_item_t;

  // result item: one utf-8 byte and its end-of-string mark
  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       final_byte;
  } out_item_t;

  // work command from front to back
  // pre_v: a held high surrogate is flushed first as a lone 3-byte sequence
  // cur_v: code point cp is encoded next, with last on its final byte
  typedef struct packed {
    logic        pre_v;
    logic [9:0]  pre_bits;
    logic        cur_v;
    logic [20:0] cp;
    logic        last;
  } cmd_t;

  // command queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // surrogate prefixes (top six bits of the code unit)
  localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;
  localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;

  // offset of the supplementary planes
  localparam logic [20:0] SUPP_BASE = 21'h10000;

  // sequence length codes (byte count minus one)
  localparam logic [1:0] LEN_1 = 2'd0;
  localparam logic [1:0] LEN_2 = 2'd1;
  localparam logic [1:0] LEN_3 = 2'd2;
  localparam logic [1:0] LEN_4 = 2'd3;

  // number of utf-8 bytes for a code point, minus one
  function automatic logic [1:0] seq_len_m1(logic [20:0] cp);
    logic [1:0] len;
    if (cp[20:7] == 14'd0) begin
      len = LEN_1;
    end else if (cp[20:11] == 10'd0) begin
      len = LEN_2;
    end else if (cp[20:16] == 5'd0) begin
      len = LEN_3;
    end else begin
      len = LEN_4;
    end
    return len;
  endfunction

  // byte number idx of the utf-8 sequence of cp
  function automatic logic [7:0] seq_byte(logic [20:0] cp, logic [1:0] len_m1,
                                          logic [1:0] idx);
    logic [1:0] pos;
    logic [7:0] b;
    pos = len_m1 - idx;
    if (idx == 2'd0) begin
      unique case (len_m1)
        LEN_1:   b = {1'b0, cp[6:0]};
        LEN_2:   b = {3'b110, cp[10:6]};
        LEN_3:   b = {4'b1110, cp[15:12]};
        default: b = {5'b11110, cp[20:18]};
      endcase
    end else begin
      // continuation byte, pos counts six-bit groups from the low end
      unique case (pos)
        2'd0:    b = {2'b10, cp[5:0]};
        2'd1:    b = {2'b10, cp[11:6]};
        default: b = {2'b10, cp[17:12]};
      endcase
    end
    return b;
  endfunction

endpackage

### design/utf16_to_utf8_encoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_encoder
// UTF-16 code units in, UTF-8 bytes out, with surrogate pairing.
// ----------------------------------------------------------------------------
// Input channel: push a code unit with in_push while in_full is low; the
// final_unit bit marks the end of a string. Result channel: a byte sits on
// out_data while out_empty is low and is taken with out_pop; final_byte is
// set on the last byte of a string.
// The front end pairs surrogates and writes at most one command per unit into a
// two-entry queue; the back end expands a command into bytes, one byte per
// cycle, limited by the single result register.
// A unit gives as many bytes as its code point needs: 1 to 3 for plane 0, 4 for
// a surrogate pair, and 3 more when a held high surrogate is flushed alone.
// A held high surrogate gives no bytes until the next unit arrives.
// The first byte of a unit passes through the command queue and the back-end
// command registers into the result register, behind any earlier queued bytes.
// When the receiver stalls, the result register holds its byte, the back end
// waits, and in_full rises once the command queue has filled.
// Reset (rst_n low, synchronous) empties the queue, drops any held surrogate
// and marks the result register empty.
// ----------------------------------------------------------------------------
module utf16_to_utf8_encoder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  u8e_pkg::in_item_t  in_data,
  output logic               in_full,
  input  logic               out_pop,
  output logic               out_empty,
  output u8e_pkg::out_item_t out_data
);

  logic          q_push;
  u8e_pkg::cmd_t q_wdata;
  logic          q_full;
  logic          q_pop;
  u8e_pkg::cmd_t q_rdata;
  logic          q_empty;

  // front end: classify and pair surrogates
  u8e_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_wdata)
  );

  // command queue
  u8e_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  // back end: byte emission
  u8e_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

  assign in_full = q_full;

endmodule

### design/u8e_front.sv
// ----------------------------------------------------------------------------
// u8e_front
// Accepts code units, tracks a held high surrogate and turns the units into
// work commands for the back end.
// ----------------------------------------------------------------------------
module u8e_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  input  u8e_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output u8e_pkg::cmd_t     q_data
);

  logic       held_v_r;
  logic       held_v_nxt;
  logic [9:0] held_bits_r;
  logic [9:0] held_bits_nxt;
  logic       accept;
  logic       is_high;
  logic       is_low;
  logic       pair;

  // classify the incoming unit
  always_comb begin
    accept  = in_push && !q_full;
    is_high = in_data.code_unit[15:10] == u8e_pkg::HIGH_SURR_TAG;
    is_low  = in_data.code_unit[15:10] == u8e_pkg::LOW_SURR_TAG;
    pair    = held_v_r && is_low;
  end

  // build the command
  always_comb begin
    q_data.pre_v    = held_v_r && !is_low;
    q_data.pre_bits = held_bits_r;
    q_data.cur_v    = !(is_high && !in_data.final_unit);
    q_data.last     = in_data.final_unit;
    if (pair) begin
      q_data.cp = {1'b0, held_bits_r, in_data.code_unit[9:0]} + u8e_pkg::SUPP_BASE;
    end else begin
      q_data.cp = {5'd0, in_data.code_unit};
    end
    q_push = accept && (q_data.pre_v || q_data.cur_v);
  end

  // held surrogate update
  always_comb begin
    held_v_nxt    = held_v_r;
    held_bits_nxt = held_bits_r;
    if (accept) begin
      held_v_nxt    = is_high && !in_data.final_unit;
      held_bits_nxt = in_data.code_unit[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_v_r <= 1'b0;
    end else begin
      held_v_r <= held_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_bits_r <= held_bits_nxt;
  end

endmodule

### design/u8e_queue.sv
// ----------------------------------------------------------------------------
// u8e_queue
// Short register queue of work commands between the front and back ends.
// ----------------------------------------------------------------------------
module u8e_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  u8e_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output u8e_pkg::cmd_t pop_data,
  output logic          empty
);

  u8e_pkg::cmd_t                   mem_r [u8e_pkg::QUEUE_DEPTH];
  logic [u8e_pkg::QUEUE_AW-1:0]    wr_ptr_r;
  logic [u8e_pkg::QUEUE_AW-1:0]    wr_ptr_nxt;
  logic [u8e_pkg::QUEUE_AW-1:0]    rd_ptr_r;
  logic [u8e_pkg::QUEUE_AW-1:0]    rd_ptr_nxt;
  logic [u8e_pkg::QUEUE_CW-1:0]    cnt_r;
  logic [u8e_pkg::QUEUE_CW-1:0]    cnt_nxt;
  logic                            do_push;
  logic                            do_pop;

  localparam logic [u8e_pkg::QUEUE_AW-1:0] LAST_PTR =
    u8e_pkg::QUEUE_AW'(u8e_pkg::QUEUE_DEPTH - 1);
  localparam logic [u8e_pkg::QUEUE_CW-1:0] FULL_CNT =
    u8e_pkg::QUEUE_CW'(u8e_pkg::QUEUE_DEPTH);

  // status
  always_comb begin
    full     = cnt_r == FULL_CNT;
    empty    = cnt_r == '0;
    pop_data = mem_r[rd_ptr_r];
    do_push  = push && !full;
    do_pop   = pop && !empty;
  end

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage write
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### design/u8e_back.sv
// ----------------------------------------------------------------------------
// u8e_back
// Takes work commands and emits their utf-8 bytes one per cycle, while the
// result register is empty or being popped, into the result register.
// ----------------------------------------------------------------------------
module u8e_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty,
  input  u8e_pkg::cmd_t      q_data,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output u8e_pkg::out_item_t out_data
);

  logic               act_r;
  logic               act_nxt;
  logic               pre_r;
  logic               pre_nxt;
  logic [9:0]         pre_bits_r;
  logic [9:0]         pre_bits_nxt;
  logic               cur_v_r;
  logic               cur_v_nxt;
  logic [20:0]        cp_r;
  logic [20:0]        cp_nxt;
  logic               last_r;
  logic               last_nxt;
  logic [1:0]         idx_r;
  logic [1:0]         idx_nxt;
  logic               out_v_r;
  logic               out_v_nxt;
  u8e_pkg::out_item_t out_r;
  u8e_pkg::out_item_t out_nxt;
  logic [20:0]        cpx;
  logic               last_eff;
  logic [1:0]         len_m1;
  logic               step;
  logic               is_end;
  logic               done;

  // select the code point being emitted
  always_comb begin
    cpx      = pre_r ? {5'd0, u8e_pkg::HIGH_SURR_TAG, pre_bits_r} : cp_r;
    last_eff = !pre_r && last_r;
    len_m1   = u8e_pkg::seq_len_m1(cpx);
    step     = act_r && (!out_v_r || out_pop);
    is_end   = idx_r == len_m1;
    done     = step && is_end && (!pre_r || !cur_v_r);
    q_pop    = !q_empty && (!act_r || done);
  end

  // byte sequencer
  always_comb begin
    act_nxt      = act_r;
    pre_nxt      = pre_r;
    pre_bits_nxt = pre_bits_r;
    cur_v_nxt    = cur_v_r;
    cp_nxt       = cp_r;
    last_nxt     = last_r;
    idx_nxt      = idx_r;
    if (step) begin
      if (is_end) begin
        idx_nxt = 2'd0;
        pre_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
    if (done) begin
      act_nxt = 1'b0;
    end
    if (q_pop) begin
      act_nxt      = 1'b1;
      pre_nxt      = q_data.pre_v;
      pre_bits_nxt = q_data.pre_bits;
      cur_v_nxt    = q_data.cur_v;
      cp_nxt       = q_data.cp;
      last_nxt     = q_data.last;
      idx_nxt      = 2'd0;
    end
  end

  // result register
  always_comb begin
    out_nxt   = out_r;
    out_v_nxt = out_v_r;
    if (step) begin
      out_nxt.utf8_byte  = u8e_pkg::seq_byte(cpx, len_m1, idx_r);
      out_nxt.final_byte = is_end && last_eff;
      out_v_nxt          = 1'b1;
    end else if (out_pop) begin
      out_v_nxt = 1'b0;
    end
    out_empty = !out_v_r;
    out_data  = out_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r   <= 1'b0;
      pre_r   <= 1'b0;
      idx_r   <= 2'd0;
      out_v_r <= 1'b0;
    end else begin
      act_r   <= act_nxt;
      pre_r   <= pre_nxt;
      idx_r   <= idx_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pre_bits_r <= pre_bits_nxt;
    cur_v_r    <= cur_v_nxt;
    cp_r       <= cp_nxt;
    last_r     <= last_nxt;
    out_r      <= out_nxt;
  end

endmodule

### design/u8e_checker.sv
// ----------------------------------------------------------------------------
// u8e_checker
// Port-level checks for the UTF-16 to UTF-8 encoder, bound to the top level.
// ----------------------------------------------------------------------------
module u8e_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_pop,
  input logic               out_empty,
  input u8e_pkg::out_item_t out_data
);

  // a waiting result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("result changed before transfer");

  // reset leaves the result side empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> out_empty)
    else $error("result present after reset");

  // reset leaves room on the input side
  a_reset_not_full: assert property (@(posedge clk)
    !rst_n |=> !in_full)
    else $error("input full after reset");

  // no lead byte beyond the four-byte form
  a_byte_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_data.utf8_byte[7:3] != 5'b11111))
    else $error("invalid utf-8 byte value");

  // the end mark never sits on a multi-byte lead byte
  a_final_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_data.final_byte) |-> (out_data.utf8_byte[7:6] != 2'b11))
    else $error("end mark on a lead byte");

endmodule

bind utf16_to_utf8_encoder u8e_checker u_u8e_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_pop   (out_pop),
  .out_empty (out_empty),
  .out_data  (out_data)
);
